### hdl/pao_pkg.sv
// Shared constants, codes and stage types of the pixel address offset unit.
package pao_pkg;

    // Wallpaper roll width in bytes
    localparam int unsigned ROLL_WIDTH = 128;
    localparam int unsigned RW_BITS    = $clog2(ROLL_WIDTH);

    localparam int unsigned COORD_W = 16;
    localparam int unsigned OFS_W   = 32;
    localparam int unsigned STR_W   = 32;
    // Widest row byte offset of x: 48 * (2^16 - 1)
    localparam int unsigned XB_W    = 22;
    localparam int unsigned BYTES_W = RW_BITS + 1;
    localparam int unsigned WPA_W   = COORD_W + RW_BITS + 1;
    localparam int unsigned ADD_W   = (WPA_W > XB_W) ? WPA_W : XB_W;

    // Samples per roll for each packing
    localparam int unsigned DIV_8  = ROLL_WIDTH;
    localparam int unsigned DIV_16 = ROLL_WIDTH / 2;
    localparam int unsigned DIV_PK = ROLL_WIDTH / 4 * 3;

    // Reciprocals for exact division of a 16-bit value by a constant
    localparam int unsigned RCP_W  = COORD_W + 1;
    localparam int unsigned PROD_W = COORD_W + RCP_W;
    localparam int unsigned K_8    = COORD_W + $clog2(DIV_8);
    localparam int unsigned K_16   = COORD_W + $clog2(DIV_16);
    localparam int unsigned K_PK   = COORD_W + $clog2(DIV_PK);
    localparam int unsigned K_R3   = COORD_W + 2;
    localparam int unsigned M_8    = ((2 ** K_8) + DIV_8 - 1) / DIV_8;
    localparam int unsigned M_16   = ((2 ** K_16) + DIV_16 - 1) / DIV_16;
    localparam int unsigned M_PK   = ((2 ** K_PK) + DIV_PK - 1) / DIV_PK;
    localparam int unsigned M_R3   = ((2 ** K_R3) + 2) / 3;

    // Reciprocal for division of a roll position by three
    localparam int unsigned K_P3   = RW_BITS + 2;
    localparam int unsigned M_P3   = ((2 ** K_P3) + 2) / 3;
    localparam int unsigned POSP_W = 2 * RW_BITS + 1;

    // Sample size codes
    localparam logic [1:0] BITS_8  = 2'd0;
    localparam logic [1:0] BITS_10 = 2'd1;
    localparam logic [1:0] BITS_12 = 2'd2;
    localparam logic [1:0] BITS_16 = 2'd3;

    // Sample kind codes
    localparam logic [1:0] KIND_PLAIN    = 2'd0;
    localparam logic [1:0] KIND_HOG_U    = 2'd1;
    localparam logic [1:0] KIND_HOG_S    = 2'd2;
    localparam logic [1:0] KIND_INTEGRAL = 2'd3;

    // Planarity codes
    localparam logic [1:0] PLAN_INTERLEAVED = 2'd0;
    localparam logic [1:0] PLAN_SEMI        = 2'd1;
    localparam logic [1:0] PLAN_PLANAR      = 2'd2;

    // Chroma sampling codes
    localparam logic [1:0] SAMP_444 = 2'd0;
    localparam logic [1:0] SAMP_422 = 2'd1;
    localparam logic [1:0] SAMP_420 = 2'd2;

    // Configuration register indexes
    typedef logic [2:0] t_cfg_index;
    localparam t_cfg_index CFG_SAMPLE_BITS   = 3'd0;
    localparam t_cfg_index CFG_SAMPLE_KIND   = 3'd1;
    localparam t_cfg_index CFG_THREE_CHANNEL = 3'd2;
    localparam t_cfg_index CFG_PLANARITY     = 3'd3;
    localparam t_cfg_index CFG_SAMPLING      = 3'd4;
    localparam t_cfg_index CFG_WALLPAPER     = 3'd5;
    localparam t_cfg_index CFG_FIRST_STRIDE  = 3'd6;
    localparam t_cfg_index CFG_SECOND_STRIDE = 3'd7;

    typedef struct packed {
        logic [1:0]       sample_bits_code;
        logic [1:0]       sample_kind;
        logic             three_channel;
        logic [1:0]       planarity;
        logic [1:0]       sampling;
        logic             wallpaper_mode;
        logic [STR_W-1:0] first_stride;
        logic [STR_W-1:0] second_stride;
    } t_cfg;

    // Per-stage advance enables
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_adv;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] rolls;
        logic [COORD_W-1:0] row_q3;
    } t_s1;

    typedef struct packed {
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] rolls;
        logic [RW_BITS-1:0] pos;
        logic [XB_W-1:0]    xb;
        logic [XB_W-1:0]    xb2;
    } t_s2;

    typedef struct packed {
        logic [OFS_W-1:0] p1;
        logic [OFS_W-1:0] p2;
        logic [ADD_W-1:0] add1;
        logic [ADD_W-1:0] add2;
        logic             mis;
    } t_s3;

endpackage

### hdl/pao_divide.sv
// Stages one and two: split x into rolls and roll position, form row byte offsets.
module pao_divide
    import pao_pkg::*;
(
    input  logic               i_clk,
    input  t_adv               i_adv,
    input  t_cfg               i_cfg,
    input  logic [COORD_W-1:0] i_x,
    input  logic [COORD_W-1:0] i_y,
    output t_s2                o_s2
);

    t_s1 r_s1, n_s1;
    t_s2 r_s2, n_s2;

    logic [PROD_W-1:0] w_p8, w_p16, w_ppk, w_pr3;

    // Stage one: quotients by reciprocal multiplication
    always_comb begin
        w_p8  = PROD_W'(i_x) * PROD_W'(M_8);
        w_p16 = PROD_W'(i_x) * PROD_W'(M_16);
        w_ppk = PROD_W'(i_x) * PROD_W'(M_PK);
        w_pr3 = PROD_W'(i_x) * PROD_W'(M_R3);
        n_s1.x      = i_x;
        n_s1.y      = i_y;
        n_s1.row_q3 = COORD_W'(w_pr3 >> K_R3);
        case (i_cfg.sample_bits_code)
            BITS_8:  n_s1.rolls = COORD_W'(w_p8 >> K_8);
            BITS_16: n_s1.rolls = COORD_W'(w_p16 >> K_16);
            default: n_s1.rolls = COORD_W'(w_ppk >> K_PK);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s1) begin
            r_s1 <= n_s1;
        end
    end

    logic [COORD_W-1:0] w_base;
    logic [COORD_W+1:0] w_x12;
    logic [XB_W-1:0]    w_b;
    logic [XB_W-1:0]    w_xb;

    // Stage two: roll position and row byte offset of x
    always_comb begin
        case (i_cfg.sample_bits_code)
            BITS_8:  w_base = COORD_W'(32'(r_s1.rolls) * DIV_8);
            BITS_16: w_base = COORD_W'(32'(r_s1.rolls) * DIV_16);
            default: w_base = COORD_W'(32'(r_s1.rolls) * DIV_PK);
        endcase

        w_x12 = {2'b00, r_s1.x} + {1'b0, r_s1.x, 1'b0} + (COORD_W+2)'(1);
        case (i_cfg.sample_bits_code)
            BITS_8:  w_b = XB_W'(r_s1.x);
            BITS_10: w_b = XB_W'(r_s1.row_q3) << 2;
            BITS_12: w_b = XB_W'(w_x12 >> 1);
            default: w_b = XB_W'(r_s1.x) << 1;
        endcase
        if (i_cfg.three_channel && i_cfg.planarity == PLAN_INTERLEAVED) begin
            if (i_cfg.sampling == SAMP_422) begin
                w_b = w_b << 1;
            end else begin
                w_b = w_b + (w_b << 1);
            end
        end

        case (i_cfg.sample_kind)
            KIND_HOG_U:    w_xb = XB_W'(r_s1.x) << 5;
            KIND_HOG_S:    w_xb = (XB_W'(r_s1.x) << 5) + (XB_W'(r_s1.x) << 4);
            KIND_INTEGRAL: w_xb = XB_W'(r_s1.x) << 2;
            default:       w_xb = w_b;
        endcase

        n_s2.y     = r_s1.y;
        n_s2.rolls = r_s1.rolls;
        n_s2.pos   = RW_BITS'(r_s1.x - w_base);
        n_s2.xb    = w_xb;
        // Halve the row byte offset of x for planar chroma that is not 4:4:4
        if (i_cfg.planarity == PLAN_PLANAR && i_cfg.sampling != SAMP_444) begin
            n_s2.xb2 = w_xb >> 1;
        end else begin
            n_s2.xb2 = w_xb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s2) begin
            r_s2 <= n_s2;
        end
    end

    assign o_s2 = r_s2;

endmodule

### hdl/pao_product.sv
// Stage three: stride products, in-roll bytes and the misalignment flag.
module pao_product
    import pao_pkg::*;
(
    input  logic i_clk,
    input  t_adv i_adv,
    input  t_cfg i_cfg,
    input  t_s2  i_s2,
    output t_s3  o_s3
);

    t_s3 r_s3, n_s3;

    logic [POSP_W-1:0]          w_pp;
    logic [RW_BITS-1:0]         w_q3;
    logic [BYTES_W-1:0]         w_bytes;
    logic                       w_packed;
    logic [COORD_W-1:0]         w_y2;
    logic [COORD_W-1:0]         w_a1, w_a2;
    logic [COORD_W+STR_W-1:0]   w_m1, w_m2;

    always_comb begin
        w_pp     = POSP_W'(i_s2.pos) * POSP_W'(M_P3);
        w_q3     = RW_BITS'(w_pp >> K_P3);
        w_packed = (i_cfg.sample_bits_code == BITS_10) || (i_cfg.sample_bits_code == BITS_12);
        case (i_cfg.sample_bits_code)
            BITS_8:  w_bytes = BYTES_W'(i_s2.pos);
            BITS_16: w_bytes = BYTES_W'(i_s2.pos) << 1;
            default: w_bytes = BYTES_W'(w_q3) << 2;
        endcase

        w_y2 = (i_cfg.sampling == SAMP_420) ? (i_s2.y >> 1) : i_s2.y;
        w_a1 = i_cfg.wallpaper_mode ? i_s2.rolls : i_s2.y;
        w_a2 = i_cfg.wallpaper_mode ? i_s2.rolls : w_y2;
        w_m1 = (COORD_W+STR_W)'(w_a1) * (COORD_W+STR_W)'(i_cfg.first_stride);
        w_m2 = (COORD_W+STR_W)'(w_a2) * (COORD_W+STR_W)'(i_cfg.second_stride);

        n_s3.p1 = OFS_W'(w_m1);
        n_s3.p2 = OFS_W'(w_m2);
        if (i_cfg.wallpaper_mode) begin
            n_s3.add1 = ADD_W'(i_s2.y) * ADD_W'(ROLL_WIDTH) + ADD_W'(w_bytes);
            n_s3.add2 = ADD_W'(i_s2.y >> 1) * ADD_W'(ROLL_WIDTH) + ADD_W'(w_bytes);
            n_s3.mis  = w_packed && (i_s2.pos != RW_BITS'(w_q3 + (w_q3 << 1)));
        end else begin
            n_s3.add1 = ADD_W'(i_s2.xb);
            n_s3.add2 = ADD_W'(i_s2.xb2);
            n_s3.mis  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s3) begin
            r_s3 <= n_s3;
        end
    end

    assign o_s3 = r_s3;

endmodule

### hdl/pao_sum.sv
// Stage four: final offset sums into the output register.
module pao_sum
    import pao_pkg::*;
(
    input  logic             i_clk,
    input  t_adv             i_adv,
    input  t_cfg             i_cfg,
    input  t_s3              i_s3,
    output logic [OFS_W-1:0] o_first_offset,
    output logic [OFS_W-1:0] o_second_offset,
    output logic             o_second_valid,
    output logic             o_roll_misaligned
);

    logic [OFS_W-1:0] r_first, n_first;
    logic [OFS_W-1:0] r_second, n_second;
    logic             r_second_valid, n_second_valid;
    logic             r_mis, n_mis;
    logic [OFS_W-1:0] w_sum2;

    always_comb begin
        n_first = i_s3.p1 + OFS_W'(i_s3.add1);
        w_sum2  = i_s3.p2 + OFS_W'(i_s3.add2);
        n_mis   = i_s3.mis;
        if (i_cfg.wallpaper_mode) begin
            n_second_valid = 1'b1;
            n_second       = (i_cfg.sampling == SAMP_420) ? w_sum2 : n_first;
        end else if (i_cfg.planarity != PLAN_INTERLEAVED) begin
            n_second_valid = 1'b1;
            n_second       = w_sum2;
        end else begin
            // Interleaved rows have no second plane
            n_second_valid = 1'b0;
            n_second       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s4) begin
            r_first        <= n_first;
            r_second       <= n_second;
            r_second_valid <= n_second_valid;
            r_mis          <= n_mis;
        end
    end

    assign o_first_offset    = r_first;
    assign o_second_offset   = r_second;
    assign o_second_valid    = r_second_valid;
    assign o_roll_misaligned = r_mis;

endmodule

### hdl/pixel_address_offset_unit.sv
// Top level of the pixel address offset unit: configuration, pipeline control, stages.
//
// Usage:
//   Each transfer on the input channel (i_valid / o_ready) carries one pixel
//   coordinate, i_pixel_x and i_pixel_y. Each transfer on the output channel
//   (o_valid / i_ready) returns one result: the byte offsets of that pixel in
//   the first and second plane, a flag saying whether the second offset is
//   defined, and a flag for a packed wallpaper position that is not a multiple
//   of three samples.
//   The configuration channel (i_cfg_valid / o_cfg_ready) writes one register
//   per transfer, selected by i_cfg_index; it is always ready. Write it only
//   while no transfer is in flight.
//   o_valid rises once the input transfer has passed the four-stage pipeline
//   (roll and row quotients, roll position and row bytes, stride products,
//   final sums), and the result transfer can follow at the next edge;
//   throughput is one coordinate per cycle while the receiver keeps i_ready high.
//   Reset clears all configuration registers to zero and empties the pipeline.
//   When the receiver holds i_ready low the run of full stages at the output holds
//   its contents; stages behind an empty stage still move up and fill, so o_ready stays high until every stage is full.
module pixel_address_offset_unit
    import pao_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [COORD_W-1:0] i_pixel_x,
    input  logic [COORD_W-1:0] i_pixel_y,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [OFS_W-1:0]   o_first_offset,
    output logic [OFS_W-1:0]   o_second_offset,
    output logic               o_second_valid,
    output logic               o_roll_misaligned,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  t_cfg_index         i_cfg_index,
    input  logic [STR_W-1:0]   i_cfg_data
);

    // Configuration registers
    t_cfg r_cfg, n_cfg;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SAMPLE_BITS:   n_cfg.sample_bits_code = i_cfg_data[1:0];
                CFG_SAMPLE_KIND:   n_cfg.sample_kind      = i_cfg_data[1:0];
                CFG_THREE_CHANNEL: n_cfg.three_channel    = i_cfg_data[0];
                CFG_PLANARITY:     n_cfg.planarity        = i_cfg_data[1:0];
                CFG_SAMPLING:      n_cfg.sampling         = i_cfg_data[1:0];
                CFG_WALLPAPER:     n_cfg.wallpaper_mode   = i_cfg_data[0];
                CFG_FIRST_STRIDE:  n_cfg.first_stride     = i_cfg_data;
                CFG_SECOND_STRIDE: n_cfg.second_stride    = i_cfg_data;
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Pipeline occupancy: a stage advances when it is empty or the next one advances
    logic [3:0] r_v, n_v;
    t_adv       w_adv;

    always_comb begin
        w_adv.s4 = !r_v[3] || i_ready;
        w_adv.s3 = !r_v[2] || w_adv.s4;
        w_adv.s2 = !r_v[1] || w_adv.s3;
        w_adv.s1 = !r_v[0] || w_adv.s2;

        n_v[0] = w_adv.s1 ? i_valid : r_v[0];
        n_v[1] = w_adv.s2 ? r_v[0]  : r_v[1];
        n_v[2] = w_adv.s3 ? r_v[1]  : r_v[2];
        n_v[3] = w_adv.s4 ? r_v[2]  : r_v[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign o_ready = w_adv.s1;
    assign o_valid = r_v[3];

    t_s2 w_s2;
    t_s3 w_s3;

    pao_divide u_divide (
        .i_clk (i_clk),
        .i_adv (w_adv),
        .i_cfg (r_cfg),
        .i_x   (i_pixel_x),
        .i_y   (i_pixel_y),
        .o_s2  (w_s2)
    );

    pao_product u_product (
        .i_clk (i_clk),
        .i_adv (w_adv),
        .i_cfg (r_cfg),
        .i_s2  (w_s2),
        .o_s3  (w_s3)
    );

    pao_sum u_sum (
        .i_clk             (i_clk),
        .i_adv             (w_adv),
        .i_cfg             (r_cfg),
        .i_s3              (w_s3),
        .o_first_offset    (o_first_offset),
        .o_second_offset   (o_second_offset),
        .o_second_valid    (o_second_valid),
        .o_roll_misaligned (o_roll_misaligned)
    );

    // Input back-pressure only when the first stage is occupied
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_v[0])
        else $error("input stalled with first stage empty");

    // A full stage held by a stall keeps its item
    a_stage3_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[2] && !w_adv.s4) |=> r_v[2])
        else $error("stage three item lost during stall");

    // Misalignment is flagged only for packed wallpaper formats
    a_mis_scope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_roll_misaligned) |->
            (r_cfg.wallpaper_mode &&
             (r_cfg.sample_bits_code == BITS_10 || r_cfg.sample_bits_code == BITS_12)))
        else $error("roll misalignment outside packed wallpaper layout");

    // An undefined second offset reads as zero
    a_second_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_second_valid) |-> (o_second_offset == '0))
        else $error("second offset non-zero while undefined");

endmodule

### sim/pixel_address_offset_check.sv
`timescale 1ns / 1ps
// Monitor for the pixel address offset unit: mirrors its registers, predicts offsets, compares.
module pixel_address_offset_check
    import pao_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [COORD_W-1:0] i_pixel_x,
    input  logic [COORD_W-1:0] i_pixel_y,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [OFS_W-1:0]   i_first_offset,
    input  logic [OFS_W-1:0]   i_second_offset,
    input  logic               i_second_valid,
    input  logic               i_roll_misaligned,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  t_cfg_index         i_cfg_index,
    input  logic [STR_W-1:0]   i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked,
    output int                 o_misaligned
);

    localparam int unsigned HOG_U_CELL_BYTES      = 32;
    localparam int unsigned HOG_S_CELL_BYTES      = 48;
    localparam int unsigned INTEGRAL_SAMPLE_BYTES = 4;

    typedef struct packed {
        logic [OFS_W-1:0] first_offset;
        logic [OFS_W-1:0] second_offset;
        logic             second_valid;
        logic             roll_misaligned;
    } t_pixel_offsets;

    // Register mirror
    logic [1:0]       fmt_bits;
    logic [1:0]       fmt_kind;
    logic             fmt_three;
    logic [1:0]       fmt_planarity;
    logic [1:0]       fmt_sampling;
    logic             fmt_wallpaper;
    logic [STR_W-1:0] fmt_stride1;
    logic [STR_W-1:0] fmt_stride2;

    t_pixel_offsets pending_offsets[$];
    int fail_total    = 0;
    int checked_total = 0;
    int flagged_total = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_misaligned = 0;
    end

    function automatic t_pixel_offsets predict_offsets(input logic [COORD_W-1:0] px,
                                                       input logic [COORD_W-1:0] py);
        t_pixel_offsets r;
        logic [31:0] x, y, per_roll, pos, rolls, nbytes, xb, y2;
        r = '0;
        x = 32'(px);
        y = 32'(py);
        if (fmt_wallpaper) begin
            // Split x into whole rolls and a sample position inside the roll
            case (fmt_bits)
                BITS_8:  per_roll = ROLL_WIDTH;
                BITS_16: per_roll = ROLL_WIDTH / 2;
                default: per_roll = ROLL_WIDTH / 4 * 3;
            endcase
            pos   = x % per_roll;
            rolls = x / per_roll;
            case (fmt_bits)
                BITS_8:  nbytes = pos;
                BITS_16: nbytes = pos * 2;
                default: begin
                    r.roll_misaligned = (pos % 3) != 0;
                    nbytes = (pos / 3) * 4;
                end
            endcase
            r.first_offset = rolls * fmt_stride1 + y * 32'(ROLL_WIDTH) + nbytes;
            if (fmt_sampling == SAMP_420)
                r.second_offset = rolls * fmt_stride2 + (y / 2) * 32'(ROLL_WIDTH) + nbytes;
            else
                r.second_offset = r.first_offset;
            r.second_valid = 1'b1;
        end else begin
            case (fmt_kind)
                KIND_HOG_U:    xb = x * HOG_U_CELL_BYTES;
                KIND_HOG_S:    xb = x * HOG_S_CELL_BYTES;
                KIND_INTEGRAL: xb = x * INTEGRAL_SAMPLE_BYTES;
                default: begin
                    case (fmt_bits)
                        BITS_8:  xb = x;
                        BITS_10: xb = (x / 3) * 4;
                        BITS_12: xb = (x * 3 + 1) / 2;
                        default: xb = x * 2;
                    endcase
                    if (fmt_three && fmt_planarity == PLAN_INTERLEAVED)
                        xb = xb * ((fmt_sampling == SAMP_422) ? 32'd2 : 32'd3);
                end
            endcase
            r.first_offset = y * fmt_stride1 + xb;
            if (fmt_planarity != PLAN_INTERLEAVED) begin
                y2 = (fmt_sampling == SAMP_420) ? y / 2 : y;
                if (fmt_planarity == PLAN_PLANAR && fmt_sampling != SAMP_444)
                    xb = xb / 2;
                r.second_offset = y2 * fmt_stride2 + xb;
                r.second_valid  = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic note_mismatch(input string field, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        fail_total++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, field, want_v, got_v);
    endtask

    always @(posedge i_clk) begin
        t_pixel_offsets want;
        if (!i_rst_n) begin
            fmt_bits      = BITS_8;
            fmt_kind      = KIND_PLAIN;
            fmt_three     = 1'b0;
            fmt_planarity = PLAN_INTERLEAVED;
            fmt_sampling  = SAMP_444;
            fmt_wallpaper = 1'b0;
            fmt_stride1   = '0;
            fmt_stride2   = '0;
            pending_offsets.delete();
        end else begin
            // Retire before predicting, so a spurious result never meets a fresh item
            if (i_out_valid && i_out_ready) begin
                if (pending_offsets.size() == 0) begin
                    fail_total++;
                    $display("%0t: result with none outstanding, expected none actual %h %h",
                             $time, i_first_offset, i_second_offset);
                end else begin
                    want = pending_offsets.pop_front();
                    checked_total++;
                    if (i_roll_misaligned)
                        flagged_total++;
                    if (i_first_offset !== want.first_offset)
                        note_mismatch("first_offset", want.first_offset, i_first_offset);
                    if (i_second_offset !== want.second_offset)
                        note_mismatch("second_offset", want.second_offset, i_second_offset);
                    if (i_second_valid !== want.second_valid)
                        note_mismatch("second_valid", 32'(want.second_valid),
                                      32'(i_second_valid));
                    if (i_roll_misaligned !== want.roll_misaligned)
                        note_mismatch("roll_misaligned", 32'(want.roll_misaligned),
                                      32'(i_roll_misaligned));
                end
            end
            if (i_in_valid && i_in_ready)
                pending_offsets.push_back(predict_offsets(i_pixel_x, i_pixel_y));
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SAMPLE_BITS:   fmt_bits      = i_cfg_data[1:0];
                    CFG_SAMPLE_KIND:   fmt_kind      = i_cfg_data[1:0];
                    CFG_THREE_CHANNEL: fmt_three     = i_cfg_data[0];
                    CFG_PLANARITY:     fmt_planarity = i_cfg_data[1:0];
                    CFG_SAMPLING:      fmt_sampling  = i_cfg_data[1:0];
                    CFG_WALLPAPER:     fmt_wallpaper = i_cfg_data[0];
                    CFG_FIRST_STRIDE:  fmt_stride1   = i_cfg_data;
                    default:           fmt_stride2   = i_cfg_data;
                endcase
            end
        end
        o_pending    <= pending_offsets.size();
        o_fail_count <= fail_total;
        o_checked    <= checked_total;
        o_misaligned <= flagged_total;
    end

endmodule

### sim/pixel_address_offset_unit_test.sv
`timescale 1ns / 1ps
// Testbench top for the pixel address offset unit: clock, reset, stimulus and verdict.
module pixel_address_offset_unit_test;
    import pao_pkg::*;

    // Codes with no name in the package: both behave as "other" in the block
    localparam logic [1:0] PLAN_OTHER = 2'd3;
    localparam logic [1:0] SAMP_OTHER = 2'd3;

    localparam int PIPE_LATENCY    = 4;
    localparam int LONG_HOLD       = 300;
    localparam int RANDOM_FORMATS  = 30;
    localparam int PIXELS_PER_FMT  = 65;
    localparam int CYCLE_LIMIT     = 1000000;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_valid     = 1'b0;
    logic               o_ready;
    logic [COORD_W-1:0] i_pixel_x   = '0;
    logic [COORD_W-1:0] i_pixel_y   = '0;
    logic               o_valid;
    logic               i_ready     = 1'b0;
    logic [OFS_W-1:0]   o_first_offset;
    logic [OFS_W-1:0]   o_second_offset;
    logic               o_second_valid;
    logic               o_roll_misaligned;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    t_cfg_index         i_cfg_index = CFG_SAMPLE_BITS;
    logic [STR_W-1:0]   i_cfg_data  = '0;

    int fail_count, pending, checked, misaligned;

    // Knobs shared by the stimulus and the receiver
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    bit long_hold_req  = 1'b0;
    bit cfg_junk       = 1'b0;
    int hold_left      = 0;
    int cycle_count    = 0;
    int format_count   = 0;
    int roll_formats   = 0;

    pixel_address_offset_unit uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_pixel_x         (i_pixel_x),
        .i_pixel_y         (i_pixel_y),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_first_offset    (o_first_offset),
        .o_second_offset   (o_second_offset),
        .o_second_valid    (o_second_valid),
        .o_roll_misaligned (o_roll_misaligned),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    pixel_address_offset_check offset_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_valid),
        .i_in_ready        (o_ready),
        .i_pixel_x         (i_pixel_x),
        .i_pixel_y         (i_pixel_y),
        .i_out_valid       (o_valid),
        .i_out_ready       (i_ready),
        .i_first_offset    (o_first_offset),
        .i_second_offset   (o_second_offset),
        .i_second_valid    (o_second_valid),
        .i_roll_misaligned (o_roll_misaligned),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_checked         (checked),
        .o_misaligned      (misaligned)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog: abandon the run if the block hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Idle length: drawn from three ranges, mostly the shortest, now and then the longest
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    // Receiver: drive i_ready once per edge; stalls are counted down here
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left--;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = LONG_HOLD - 1;
            i_ready      <= 1'b0;
        end else if ($urandom_range(0, 99) < sink_stall_pct) begin
            hold_left = rand_gap() - 1;
            i_ready  <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Offer one coordinate and return at the edge that accepts it. Valid is only
    // dropped when a gap precedes the item, so it never falls and rises in one step.
    task automatic send_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
        int gap;
        gap = ($urandom_range(0, 99) < src_idle_pct) ? rand_gap() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_pixel_x <= x;
        i_pixel_y <= y;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Hold the sender until every outstanding result has been returned
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (PIPE_LATENCY) @(posedge i_clk);
    endtask

    // Keep valid high across back-to-back register writes; the caller drops it
    task automatic write_reg(input t_cfg_index idx, input logic [STR_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Narrow registers ignore their upper data bits; fill them with noise at times
    function automatic logic [STR_W-1:0] with_noise(input logic [STR_W-1:0] v, input int w);
        if (cfg_junk && $urandom_range(0, 1) == 1)
            return v | (STR_W'($urandom) << w);
        return v;
    endfunction

    task automatic apply_format(input logic [1:0] bits, input logic [1:0] kind,
                                input logic three, input logic [1:0] plan,
                                input logic [1:0] samp, input logic wall,
                                input logic [STR_W-1:0] s1, input logic [STR_W-1:0] s2);
        drain_results();
        write_reg(CFG_SAMPLE_BITS,   with_noise(32'(bits), 2));
        write_reg(CFG_SAMPLE_KIND,   with_noise(32'(kind), 2));
        write_reg(CFG_THREE_CHANNEL, with_noise(32'(three), 1));
        write_reg(CFG_PLANARITY,     with_noise(32'(plan), 2));
        write_reg(CFG_SAMPLING,      with_noise(32'(samp), 2));
        write_reg(CFG_WALLPAPER,     with_noise(32'(wall), 1));
        write_reg(CFG_FIRST_STRIDE,  s1);
        write_reg(CFG_SECOND_STRIDE, s2);
        i_cfg_valid <= 1'b0;
        format_count++;
        if (wall)
            roll_formats++;
    endtask

    function automatic logic [STR_W-1:0] rand_stride();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r == 2)
            return $urandom;
        if (r < 6)
            return $urandom_range(0, 4096);
        return $urandom_range(0, 1 << 20);
    endfunction

    // Coordinate x: extremes, roll edges (multiples of 32 cover all roll sizes), or anything
    function automatic logic [COORD_W-1:0] rand_x();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return ($urandom_range(0, 1) == 1) ? '1 : '0;
        if (r < 30)
            return COORD_W'($urandom_range(0, 2047) * 32 + $urandom_range(0, 3) - 1);
        return $urandom_range(0, 65535);
    endfunction

    function automatic logic [COORD_W-1:0] rand_y();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return ($urandom_range(0, 1) == 1) ? '1 : '0;
        if (r < 40)
            return $urandom_range(0, 1023);
        return $urandom_range(0, 65535);
    endfunction

    initial begin
        int phase, n, run_left;
        logic [COORD_W-1:0] scan_x, scan_y;
        bit raster;

        // Hold reset, then release it at an edge
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset format first, then extremes and a selection of corners of the format space
        sink_stall_pct = 20;
        send_pixel('0, '0);
        send_pixel('1, '1);
        apply_format(BITS_8, KIND_HOG_U, 1'b0, PLAN_SEMI, SAMP_444, 1'b0, '1, '1);
        send_pixel('1, '1);
        apply_format(BITS_8, KIND_HOG_S, 1'b1, PLAN_PLANAR, SAMP_420, 1'b0, 1920, 960);
        send_pixel('1, 1);
        send_pixel(3, 3);
        apply_format(BITS_16, KIND_INTEGRAL, 1'b0, PLAN_INTERLEAVED, SAMP_444, 1'b0, 4096, 0);
        send_pixel(1000, 7);
        // Three-channel interleaved 4:2:2 doubles the row bytes
        apply_format(BITS_10, KIND_PLAIN, 1'b1, PLAN_INTERLEAVED, SAMP_422, 1'b0, 5120, 0);
        send_pixel('1, 3);
        send_pixel(4, 2);
        apply_format(BITS_12, KIND_PLAIN, 1'b0, PLAN_PLANAR, SAMP_420, 1'b0, 3000, 1500);
        send_pixel('1, '1);
        send_pixel(2, 5);
        // Unnamed planarity and sampling codes
        apply_format(BITS_16, KIND_PLAIN, 1'b1, PLAN_OTHER, SAMP_OTHER, 1'b0, 2048, 1024);
        send_pixel(7, 9);
        apply_format(BITS_8, KIND_PLAIN, 1'b0, PLAN_PLANAR, SAMP_OTHER, 1'b0, 640, 320);
        send_pixel(5, 5);
        apply_format(BITS_8, KIND_PLAIN, 1'b1, PLAN_INTERLEAVED, SAMP_OTHER, 1'b0, 0, 0);
        send_pixel('1, 0);
        // Wallpaper rolls: sample kind is ignored, packed rolls may be misaligned
        apply_format(BITS_8, KIND_HOG_S, 1'b0, PLAN_INTERLEAVED, SAMP_444, 1'b1,
                     32'h0001_0000, 0);
        send_pixel('1, '1);
        send_pixel(127, 1);
        apply_format(BITS_10, KIND_PLAIN, 1'b0, PLAN_SEMI, SAMP_420, 1'b1, 65536, 32768);
        send_pixel(95, 3);
        send_pixel(96, 2);
        apply_format(BITS_12, KIND_PLAIN, 1'b1, PLAN_PLANAR, SAMP_422, 1'b1, '1, '1);
        send_pixel('1, 0);
        send_pixel(98, 1);
        apply_format(BITS_16, KIND_PLAIN, 1'b0, PLAN_SEMI, SAMP_420, 1'b1, 8192, 4096);
        send_pixel(64, '1);

        // Random formats, each with a burst of coordinates
        cfg_junk = 1'b1;
        for (phase = 0; phase < RANDOM_FORMATS; phase++) begin
            apply_format($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 1),
                         $urandom_range(0, 3), $urandom_range(0, 3),
                         $urandom_range(0, 9) < 4, rand_stride(), rand_stride());
            case ($urandom_range(0, 3))
                0:       src_idle_pct = 0;
                1:       src_idle_pct = 5;
                2:       src_idle_pct = 25;
                default: src_idle_pct = 60;
            endcase
            case ($urandom_range(0, 3))
                0:       sink_stall_pct = 0;
                1:       sink_stall_pct = 5;
                2:       sink_stall_pct = 25;
                default: sink_stall_pct = 60;
            endcase
            // Back-pressure: receiver stalls long while the sender keeps offering
            if (phase == 2) begin
                src_idle_pct  = 0;
                long_hold_req = 1'b1;
            end
            // Raster scans walk along a row, as a DMA engine would
            raster   = $urandom_range(0, 2) == 0;
            run_left = 0;
            scan_x   = '0;
            scan_y   = '0;
            for (n = 0; n < PIXELS_PER_FMT; n++) begin
                if (phase == 5 && n == PIXELS_PER_FMT / 2)
                    drain_results();
                if (raster) begin
                    if (run_left == 0) begin
                        run_left = $urandom_range(8, 40);
                        scan_x   = rand_x();
                        scan_y   = rand_y();
                    end
                    send_pixel(scan_x, scan_y);
                    scan_x++;
                    run_left--;
                end else begin
                    send_pixel(rand_x(), rand_y());
                end
            end
        end

        // Let the pipeline empty, then keep the clock running for stray results
        drain_results();
        repeat (2 * PIPE_LATENCY) @(posedge i_clk);

        $display("Checked %0d pixel offsets across %0d formats, %0d of them in roll layout.",
                 checked, format_count, roll_formats);
        $display("Misaligned packed roll positions seen: %0d.", misaligned);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
